// File: src/sps_pkg.sv
package sps_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int RANGE_W     = SAMPLE_BITS + 1;
  localparam int TH_W        = SAMPLE_BITS + 10;
  localparam int D2_W        = 2 * ADDR_W;
  localparam int VAR_W       = ADDR_W + D2_W;
  localparam int DIV_NUM_W   = 64;
  localparam int DIV_DEN_W   = ADDR_W + CNT_W;
  localparam int Q_FRAC      = 16;
  localparam int NUM_FN      = 5;

  localparam int PK_SCALE    = 100;
  localparam int PK_RISE_PCT = 11;
  localparam int PK_FALL_PCT = 9;

  localparam logic [2:0] FN_COUNT      = 3'd0;
  localparam logic [2:0] FN_MEAN_DIST  = 3'd1;
  localparam logic [2:0] FN_PEAK_MEAN  = 3'd2;
  localparam logic [2:0] FN_PEAK_MINUS = 3'd3;
  localparam logic [2:0] FN_STDDEV     = 3'd4;
  localparam logic [2:0] FN_END        = 3'd5;

  localparam logic [1:0] REG_MASK    = 2'd0;
  localparam logic [1:0] REG_OVERLAP = 2'd1;
  localparam logic [1:0] REG_TNORM   = 2'd2;
  localparam logic [1:0] REG_PERIOD  = 2'd3;

  localparam logic [1:0] TN_FRAMES  = 2'd0;
  localparam logic [1:0] TN_SECONDS = 2'd1;
  localparam logic [1:0] TN_SEGMENT = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [NUM_FN-1:0] mask;
    logic              overlap;
    logic [1:0]        tnorm;
    logic [31:0]       period;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]        n;
    sample_t                 min;
    sample_t                 max;
    logic signed [SUM_W-1:0] sum;
  } seg_t;

  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic [CNT_W-1:0]        np;
    logic signed [SUM_W-1:0] ps;
    logic [ADDR_W-1:0]       nd;
    logic [ADDR_W-1:0]       d1;
    logic [D2_W-1:0]         d2;
    logic signed [SUM_W-1:0] sum;
  } summ_t;

  typedef enum logic [1:0] {SC_IDLE, SC_RD, SC_EX, SC_FIN} scan_state_t;
  typedef enum logic [1:0] {PH_SEED_A, PH_SEED_B, PH_SCAN} scan_phase_t;

  typedef enum logic [3:0] {
    CA_IDLE, CA_MD_MUL, CA_MD_DIV, CA_SD_MUL, CA_SD_DIV, CA_SD_SQRT, CA_SD_SCALE,
    CA_SD_DIV2, CA_PM, CA_PM_DIV, CA_MN, CA_MN_DIV, CA_COMBINE, CA_EMIT
  } calc_state_t;

endpackage

// File: src/segment_peak_statistics.sv
// Channel   Handshake              Payload
// input     push / full            in_sample, in_last_sample
// result    empty / pop            out_value, out_which, out_last_result
// config    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// A sample is taken on push when full is low; samples enter back to back.
// The peak pass reads each stored sample in a read state, then an examine state.
// The closing math runs on one 64-step divider and a 32-step root;
// the root and its divisions run only for a segment with two or more peaks.
// full holds while a closed segment waits for, or is in, the peak pass.
// Synchronous reset; the result register drops on reset.
module segment_peak_statistics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_sample,
  input  logic               in_last_sample,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_which,
  output logic               out_last_result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  sps_pkg::cfg_t                 cfg_r;
  logic                          wr;
  logic                          scan_busy, seg_valid, seg_ready, summ_valid, summ_ready;
  sps_pkg::seg_t                 seg;
  sps_pkg::summ_t                summ;
  logic [sps_pkg::ADDR_W-1:0]    rd_addr;
  sps_pkg::sample_t              rd_data;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mask: 5'd15, overlap: 1'b1, tnorm: sps_pkg::TN_FRAMES, period: 32'd655};
    end else if (wr) begin
      unique case (paddr[3:2])
        sps_pkg::REG_MASK:    cfg_r.mask    <= pwdata[4:0];
        sps_pkg::REG_OVERLAP: cfg_r.overlap <= pwdata[0];
        sps_pkg::REG_TNORM:   cfg_r.tnorm   <= pwdata[1:0];
        sps_pkg::REG_PERIOD:  cfg_r.period  <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sps_pkg::REG_MASK:    prdata = 32'(cfg_r.mask);
      sps_pkg::REG_OVERLAP: prdata = 32'(cfg_r.overlap);
      sps_pkg::REG_TNORM:   prdata = 32'(cfg_r.tnorm);
      sps_pkg::REG_PERIOD:  prdata = cfg_r.period;
    endcase
  end

  sps_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .in_sample(in_sample),
    .in_last_sample(in_last_sample), .full(full), .scan_busy(scan_busy),
    .seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  sps_scan u_scan (
    .clk(clk), .rst_n(rst_n), .overlap(cfg_r.overlap), .seg_valid(seg_valid),
    .seg(seg), .seg_ready(seg_ready), .busy(scan_busy), .rd_addr(rd_addr),
    .rd_data(rd_data), .summ_valid(summ_valid), .summ(summ), .summ_ready(summ_ready)
  );

  sps_calc u_calc (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .summ_valid(summ_valid), .summ(summ),
    .summ_ready(summ_ready), .pop(pop), .empty(empty), .out_value(out_value),
    .out_which(out_which), .out_last_result(out_last_result)
  );

endmodule

// File: src/sps_front.sv
module sps_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  sps_pkg::sample_t                in_sample,
  input  logic                            in_last_sample,
  output logic                            full,
  input  logic                            scan_busy,
  output logic                            seg_valid,
  input  logic                            seg_ready,
  output sps_pkg::seg_t                   seg,
  input  logic [sps_pkg::ADDR_W-1:0]      rd_addr,
  output sps_pkg::sample_t                rd_data
);

  sps_pkg::sample_t                 mem [sps_pkg::MAX_SAMPLES];
  logic [sps_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  sps_pkg::sample_t                 min_r, min_nxt, max_r, max_nxt;
  logic signed [sps_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic                             q_valid_r;
  sps_pkg::seg_t                    q_r;
  logic                             accept, store;

  assign full      = q_valid_r | scan_busy;
  assign accept    = push & ~full;
  assign store     = accept & (cnt_r < sps_pkg::CNT_W'(sps_pkg::MAX_SAMPLES));
  assign seg_valid = q_valid_r;
  assign seg       = q_r;

  always_comb begin
    cnt_nxt = cnt_r;
    min_nxt = min_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    if (store) begin
      if (cnt_r == '0) begin
        min_nxt = in_sample;
        max_nxt = in_sample;
        sum_nxt = sps_pkg::SUM_W'(in_sample);
      end else begin
        if (in_sample < min_r) min_nxt = in_sample;
        if (in_sample > max_r) max_nxt = in_sample;
        sum_nxt = sum_r + sps_pkg::SUM_W'(in_sample);
      end
      cnt_nxt = cnt_r + sps_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (accept && in_last_sample) begin
        cnt_r     <= '0;
        q_valid_r <= 1'b1;
        q_r       <= '{n: cnt_nxt, min: min_nxt, max: max_nxt, sum: sum_nxt};
      end else begin
        cnt_r <= cnt_nxt;
        if (seg_ready) q_valid_r <= 1'b0;
      end
    end
    min_r <= min_nxt;
    max_r <= max_nxt;
    sum_r <= sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (store) mem[cnt_r[sps_pkg::ADDR_W-1:0]] <= in_sample;
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/sps_scan.sv
module sps_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       overlap,
  input  logic                       seg_valid,
  input  sps_pkg::seg_t              seg,
  output logic                       seg_ready,
  output logic                       busy,
  output logic [sps_pkg::ADDR_W-1:0] rd_addr,
  input  sps_pkg::sample_t           rd_data,
  output logic                       summ_valid,
  output sps_pkg::summ_t             summ,
  input  logic                       summ_ready
);

  localparam int TH_W = sps_pkg::TH_W;

  sps_pkg::scan_state_t             st_r, st_nxt;
  sps_pkg::scan_phase_t             ph_r, ph_nxt;
  logic [sps_pkg::CNT_W-1:0]        idx_r, idx_nxt, n_r, n_nxt, np_r, np_nxt;
  logic signed [sps_pkg::RANGE_W:0] range_r, range_nxt;
  logic signed [sps_pkg::SUM_W-1:0] sum_r, sum_nxt, ps_r, ps_nxt;
  sps_pkg::sample_t                 a_r, a_nxt, b_r, b_nxt, pa_r, pa_nxt, pb_r, pb_nxt;
  sps_pkg::sample_t                 lmax_r, lmax_nxt, lmin_r, lmin_nxt;
  logic                             flag_r, flag_nxt, lpv_r, lpv_nxt;
  logic [sps_pkg::ADDR_W-1:0]       cur_r, cur_nxt, lpos_r, lpos_nxt;
  logic [sps_pkg::ADDR_W-1:0]       nd_r, nd_nxt, d1_r, d1_nxt, d;
  logic [sps_pkg::D2_W-1:0]         d2_r, d2_nxt;
  logic [sps_pkg::ADDR_W-1:0]       i;
  logic                             loc_max, loc_min, last_i;
  logic signed [TH_W-1:0]           th_hi, th_fall;

  assign rd_addr = idx_r[sps_pkg::ADDR_W-1:0];
  assign busy    = (st_r == sps_pkg::SC_RD) || (st_r == sps_pkg::SC_EX);
  assign i       = idx_r[sps_pkg::ADDR_W-1:0];
  assign last_i  = (idx_r == n_r - sps_pkg::CNT_W'(1));
  assign loc_max = (a_r < b_r) && (b_r > rd_data);
  assign loc_min = (a_r > b_r) && (b_r < rd_data);
  assign summ    = '{n: n_r, np: np_r, ps: ps_r, nd: nd_r, d1: d1_r, d2: d2_r, sum: sum_r};

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; idx_nxt = idx_r; n_nxt = n_r; np_nxt = np_r;
    range_nxt = range_r; sum_nxt = sum_r; ps_nxt = ps_r;
    a_nxt = a_r; b_nxt = b_r; pa_nxt = pa_r; pb_nxt = pb_r;
    lmax_nxt = lmax_r; lmin_nxt = lmin_r; flag_nxt = flag_r; lpv_nxt = lpv_r;
    cur_nxt = cur_r; lpos_nxt = lpos_r; nd_nxt = nd_r; d1_nxt = d1_r; d2_nxt = d2_r;
    d = '0; th_hi = '0; th_fall = '0;
    seg_ready = 1'b0; summ_valid = 1'b0;
    unique case (st_r)
      sps_pkg::SC_IDLE: begin
        if (seg_valid) begin
          seg_ready = 1'b1;
          n_nxt     = seg.n;
          sum_nxt   = seg.sum;
          range_nxt = (sps_pkg::RANGE_W+1)'(seg.max) - (sps_pkg::RANGE_W+1)'(seg.min);
          np_nxt = '0; ps_nxt = '0; nd_nxt = '0; d1_nxt = '0; d2_nxt = '0;
          lmax_nxt = '0; lmin_nxt = '0; flag_nxt = 1'b0; cur_nxt = '0; lpv_nxt = 1'b0;
          idx_nxt = '0;
          st_nxt  = sps_pkg::SC_RD;
          if (overlap) begin
            ph_nxt = sps_pkg::PH_SEED_A;
          end else begin
            ph_nxt = sps_pkg::PH_SCAN;
            a_nxt  = pa_r;
            b_nxt  = pb_r;
          end
        end
      end
      sps_pkg::SC_RD: st_nxt = sps_pkg::SC_EX;
      sps_pkg::SC_EX: begin
        unique case (ph_r)
          sps_pkg::PH_SEED_A: begin
            a_nxt = rd_data;
            if (n_r > sps_pkg::CNT_W'(1)) begin
              ph_nxt  = sps_pkg::PH_SEED_B;
              idx_nxt = sps_pkg::CNT_W'(1);
              st_nxt  = sps_pkg::SC_RD;
            end else begin
              b_nxt  = rd_data;
              st_nxt = sps_pkg::SC_FIN;
            end
          end
          sps_pkg::PH_SEED_B: begin
            b_nxt   = rd_data;
            idx_nxt = sps_pkg::CNT_W'(2);
            ph_nxt  = sps_pkg::PH_SCAN;
            st_nxt  = (n_r > sps_pkg::CNT_W'(2)) ? sps_pkg::SC_RD : sps_pkg::SC_FIN;
          end
          default: begin
            if (loc_max) begin
              if (!flag_r) begin
                lmax_nxt = rd_data;
              end else if (rd_data > lmax_r) begin
                lmax_nxt = rd_data;
                cur_nxt  = i;
              end
              th_hi = TH_W'((TH_W'(lmax_nxt) - TH_W'(lmin_r)) * sps_pkg::PK_SCALE);
              if (th_hi > TH_W'(range_r * sps_pkg::PK_RISE_PCT)) begin
                flag_nxt = 1'b1;
                cur_nxt  = i;
              end
            end else if (loc_min) begin
              lmin_nxt = rd_data;
            end
            th_fall = TH_W'(lmax_nxt * sps_pkg::PK_SCALE)
                    - TH_W'(range_r * sps_pkg::PK_FALL_PCT);
            if (flag_nxt && ((TH_W'(rd_data * sps_pkg::PK_SCALE) < th_fall) || last_i)) begin
              np_nxt = np_r + sps_pkg::CNT_W'(1);
              ps_nxt = ps_r + sps_pkg::SUM_W'(lmax_nxt);
              if (lpv_r) begin
                d      = cur_nxt - lpos_r;
                nd_nxt = nd_r + sps_pkg::ADDR_W'(1);
                d1_nxt = d1_r + d;
                d2_nxt = d2_r + sps_pkg::D2_W'(d) * sps_pkg::D2_W'(d);
              end
              lpos_nxt = cur_nxt;
              lpv_nxt  = 1'b1;
              flag_nxt = 1'b0;
            end
            a_nxt   = b_r;
            b_nxt   = rd_data;
            idx_nxt = idx_r + sps_pkg::CNT_W'(1);
            st_nxt  = last_i ? sps_pkg::SC_FIN : sps_pkg::SC_RD;
          end
        endcase
      end
      sps_pkg::SC_FIN: begin
        summ_valid = 1'b1;
        if (summ_ready) begin
          pa_nxt = a_r;
          pb_nxt = b_r;
          st_nxt = sps_pkg::SC_IDLE;
        end
      end
      default: st_nxt = sps_pkg::SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sps_pkg::SC_IDLE;
      pa_r <= '0;
      pb_r <= '0;
    end else begin
      st_r <= st_nxt;
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
    ph_r <= ph_nxt; idx_r <= idx_nxt; n_r <= n_nxt; np_r <= np_nxt;
    range_r <= range_nxt; sum_r <= sum_nxt; ps_r <= ps_nxt;
    a_r <= a_nxt; b_r <= b_nxt; lmax_r <= lmax_nxt; lmin_r <= lmin_nxt;
    flag_r <= flag_nxt; lpv_r <= lpv_nxt; cur_r <= cur_nxt; lpos_r <= lpos_nxt;
    nd_r <= nd_nxt; d1_r <= d1_nxt; d2_r <= d2_nxt;
  end

endmodule

// File: src/sps_div.sv
module sps_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sps_pkg::DIV_NUM_W-1:0] num,
  input  logic [sps_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [sps_pkg::DIV_NUM_W-1:0] quo
);

  localparam int NW = sps_pkg::DIV_NUM_W;
  localparam int DW = sps_pkg::DIV_DEN_W;

  logic [NW-1:0]            quo_r;
  logic [DW-1:0]            rem_r, den_r;
  logic [$clog2(NW+1)-1:0]  cnt_r;
  logic                     run_r, done_r;
  logic [DW:0]              trial;
  logic                     fit;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fit   = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= ($clog2(NW+1))'(NW);
        quo_r <= num;
        rem_r <= '0;
        den_r <= den;
      end else if (run_r) begin
        quo_r <= {quo_r[NW-2:0], fit};
        rem_r <= fit ? DW'(trial - {1'b0, den_r}) : DW'(trial);
        cnt_r <= cnt_r - ($clog2(NW+1))'(1);
        if (cnt_r == ($clog2(NW+1))'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/sps_sqrt.sv
module sps_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] x_r;
  logic [33:0] rem_r, rem2, trial;
  logic [31:0] root_r;
  logic [5:0]  cnt_r;
  logic        run_r, done_r, fit;

  assign rem2  = {rem_r[31:0], x_r[63:62]};
  assign trial = {root_r, 2'b01};
  assign fit   = rem2 >= trial;
  assign done  = done_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        cnt_r  <= 6'd32;
        x_r    <= x;
        rem_r  <= '0;
        root_r <= '0;
      end else if (run_r) begin
        x_r    <= {x_r[61:0], 2'b00};
        rem_r  <= fit ? rem2 - trial : rem2;
        root_r <= {root_r[30:0], fit};
        cnt_r  <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/sps_calc.sv
module sps_calc (
  input  logic               clk,
  input  logic               rst_n,
  input  sps_pkg::cfg_t      cfg,
  input  logic               summ_valid,
  input  sps_pkg::summ_t     summ,
  output logic               summ_ready,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_which,
  output logic               out_last_result
);

  localparam int NW = sps_pkg::DIV_NUM_W;
  localparam int DW = sps_pkg::DIV_DEN_W;
  localparam logic signed [34:0] S_MAX = 35'sd2147483647;
  localparam logic signed [34:0] S_MIN = -35'sd2147483648;

  sps_pkg::calc_state_t        st_r, st_nxt;
  sps_pkg::summ_t              s_r;
  logic [NW-1:0]               num_r, div_quo;
  logic [DW-1:0]               den_r;
  logic                        dstart_r, sqstart_r, div_done, sq_done, load_out;
  logic [31:0]                 sq_root;
  logic signed [31:0]          v1_r, v2_r, v3_r, v4_r, sel_val;
  logic signed [33:0]          pm_r, mean_r;
  logic [2:0]                  k_r;
  logic                        out_v_r;
  logic [sps_pkg::CNT_W-1:0]   md_dsum;
  logic [sps_pkg::ADDR_W-1:0]  md_dcnt;
  logic [DW-1:0]               md_den;
  logic [NW-1:0]               md_num;
  logic [sps_pkg::VAR_W-1:0]   sd_var;
  logic [sps_pkg::SUM_W-1:0]   ps_mag, sum_mag;
  logic signed [34:0]          pm_diff;

  function automatic logic signed [31:0] satu(input logic [NW-1:0] q);
    satu = (q > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[31:0];
  endfunction

  function automatic logic signed [31:0] sats(input logic signed [34:0] x);
    logic signed [31:0] r;
    if (x > S_MAX) r = 32'sh7FFF_FFFF;
    else if (x < S_MIN) r = 32'sh8000_0000;
    else r = x[31:0];
    sats = r;
  endfunction

  sps_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart_r), .num(num_r), .den(den_r),
    .done(div_done), .quo(div_quo)
  );

  sps_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqstart_r), .x(div_quo),
    .done(sq_done), .root(sq_root)
  );

  assign md_dsum = (s_r.nd != '0) ? sps_pkg::CNT_W'(s_r.d1) : s_r.n + sps_pkg::CNT_W'(1);
  assign md_dcnt = (s_r.nd != '0) ? s_r.nd : sps_pkg::ADDR_W'(1);
  assign md_den  = (cfg.tnorm == sps_pkg::TN_SEGMENT) ?
                   DW'(DW'(md_dcnt) * DW'(s_r.n)) : DW'(md_dcnt);
  assign md_num  = (cfg.tnorm == sps_pkg::TN_SECONDS) ?
                   NW'(md_dsum) * NW'(cfg.period) : NW'(md_dsum) << sps_pkg::Q_FRAC;
  assign sd_var  = sps_pkg::VAR_W'(s_r.nd) * sps_pkg::VAR_W'(s_r.d2)
                 - sps_pkg::VAR_W'(s_r.d1) * sps_pkg::VAR_W'(s_r.d1);
  assign ps_mag  = s_r.ps[sps_pkg::SUM_W-1] ? sps_pkg::SUM_W'(-s_r.ps) : s_r.ps;
  assign sum_mag = s_r.sum[sps_pkg::SUM_W-1] ? sps_pkg::SUM_W'(-s_r.sum) : s_r.sum;
  assign pm_diff = 35'(pm_r) - 35'(mean_r);

  assign empty = ~out_v_r;

  always_comb begin
    unique case (k_r)
      sps_pkg::FN_COUNT:      sel_val = 32'({s_r.np, 16'h0000});
      sps_pkg::FN_MEAN_DIST:  sel_val = v1_r;
      sps_pkg::FN_PEAK_MEAN:  sel_val = v2_r;
      sps_pkg::FN_PEAK_MINUS: sel_val = v3_r;
      sps_pkg::FN_STDDEV:     sel_val = v4_r;
      default:                sel_val = '0;
    endcase
  end

  always_comb begin
    st_nxt     = st_r;
    summ_ready = 1'b0;
    load_out   = 1'b0;
    unique case (st_r)
      sps_pkg::CA_IDLE: begin
        if (summ_valid) begin
          summ_ready = 1'b1;
          st_nxt     = sps_pkg::CA_MD_MUL;
        end
      end
      sps_pkg::CA_MD_MUL: st_nxt = sps_pkg::CA_MD_DIV;
      sps_pkg::CA_MD_DIV: begin
        if (div_done) st_nxt = (s_r.nd != '0) ? sps_pkg::CA_SD_MUL : sps_pkg::CA_PM;
      end
      sps_pkg::CA_SD_MUL: st_nxt = sps_pkg::CA_SD_DIV;
      sps_pkg::CA_SD_DIV: begin
        if (div_done) st_nxt = sps_pkg::CA_SD_SQRT;
      end
      sps_pkg::CA_SD_SQRT: begin
        if (sq_done) begin
          unique case (cfg.tnorm)
            sps_pkg::TN_SECONDS: st_nxt = sps_pkg::CA_SD_SCALE;
            sps_pkg::TN_SEGMENT: st_nxt = sps_pkg::CA_SD_DIV2;
            default:             st_nxt = sps_pkg::CA_PM;
          endcase
        end
      end
      sps_pkg::CA_SD_SCALE: st_nxt = sps_pkg::CA_PM;
      sps_pkg::CA_SD_DIV2: begin
        if (div_done) st_nxt = sps_pkg::CA_PM;
      end
      sps_pkg::CA_PM: st_nxt = (s_r.np != '0) ? sps_pkg::CA_PM_DIV : sps_pkg::CA_MN;
      sps_pkg::CA_PM_DIV: begin
        if (div_done) st_nxt = sps_pkg::CA_MN;
      end
      sps_pkg::CA_MN: st_nxt = sps_pkg::CA_MN_DIV;
      sps_pkg::CA_MN_DIV: begin
        if (div_done) st_nxt = sps_pkg::CA_COMBINE;
      end
      sps_pkg::CA_COMBINE: st_nxt = sps_pkg::CA_EMIT;
      sps_pkg::CA_EMIT: begin
        if (k_r == sps_pkg::FN_END) st_nxt = sps_pkg::CA_IDLE;
        else if (cfg.mask[k_r] && (!out_v_r || pop)) load_out = 1'b1;
      end
      default: st_nxt = sps_pkg::CA_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= sps_pkg::CA_IDLE;
      dstart_r  <= 1'b0;
      sqstart_r <= 1'b0;
      out_v_r   <= 1'b0;
      k_r       <= '0;
    end else begin
      st_r      <= st_nxt;
      dstart_r  <= 1'b0;
      sqstart_r <= 1'b0;
      unique case (st_r)
        sps_pkg::CA_IDLE: begin
          if (summ_valid) s_r <= summ;
        end
        sps_pkg::CA_MD_MUL: begin
          num_r    <= md_num + NW'(md_den >> 1);
          den_r    <= md_den;
          dstart_r <= 1'b1;
        end
        sps_pkg::CA_MD_DIV: begin
          if (div_done) begin
            v1_r <= satu(div_quo);
            v4_r <= '0;
          end
        end
        sps_pkg::CA_SD_MUL: begin
          num_r    <= NW'({sd_var, 32'h0000_0000});
          den_r    <= DW'(DW'(s_r.nd) * DW'(s_r.nd));
          dstart_r <= 1'b1;
        end
        sps_pkg::CA_SD_DIV: begin
          if (div_done) sqstart_r <= 1'b1;
        end
        sps_pkg::CA_SD_SQRT: begin
          if (sq_done) begin
            unique case (cfg.tnorm)
              sps_pkg::TN_SECONDS: num_r <= NW'(sq_root) * NW'(cfg.period);
              sps_pkg::TN_SEGMENT: begin
                num_r    <= NW'(sq_root) + NW'(s_r.n >> 1);
                den_r    <= DW'(s_r.n);
                dstart_r <= 1'b1;
              end
              default: v4_r <= satu(NW'(sq_root));
            endcase
          end
        end
        sps_pkg::CA_SD_SCALE: v4_r <= satu((num_r + NW'(32768)) >> sps_pkg::Q_FRAC);
        sps_pkg::CA_SD_DIV2: begin
          if (div_done) v4_r <= satu(div_quo);
        end
        sps_pkg::CA_PM: begin
          if (s_r.np != '0) begin
            num_r    <= (NW'(ps_mag) << sps_pkg::Q_FRAC) + NW'(s_r.np >> 1);
            den_r    <= DW'(s_r.np);
            dstart_r <= 1'b1;
          end else begin
            pm_r <= '0;
          end
        end
        sps_pkg::CA_PM_DIV: begin
          if (div_done) begin
            pm_r <= s_r.ps[sps_pkg::SUM_W-1] ? -$signed(34'(div_quo)) : $signed(34'(div_quo));
          end
        end
        sps_pkg::CA_MN: begin
          num_r    <= (NW'(sum_mag) << sps_pkg::Q_FRAC) + NW'(s_r.n >> 1);
          den_r    <= DW'(s_r.n);
          dstart_r <= 1'b1;
        end
        sps_pkg::CA_MN_DIV: begin
          if (div_done) begin
            mean_r <= s_r.sum[sps_pkg::SUM_W-1] ?
                      -$signed(34'(div_quo)) : $signed(34'(div_quo));
          end
        end
        sps_pkg::CA_COMBINE: begin
          v2_r <= sats(35'(pm_r));
          v3_r <= sats(pm_diff);
          k_r  <= '0;
        end
        sps_pkg::CA_EMIT: begin
          if (k_r != sps_pkg::FN_END && (!cfg.mask[k_r] || load_out)) begin
            k_r <= k_r + 3'd1;
          end
        end
        default: ;
      endcase
      if (load_out) begin
        out_v_r         <= 1'b1;
        out_value       <= sel_val;
        out_which       <= k_r;
        out_last_result <= ((cfg.mask >> k_r) >> 1) == '0;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

endmodule

// File: src/sps_check.sv
module sps_check (
  input logic               clk,
  input logic               rst_n,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] out_value,
  input logic [2:0]         out_which,
  input logic               out_last_result,
  input logic               psel,
  input logic               pwrite,
  input logic [3:0]         paddr,
  input logic [31:0]        prdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_value) && $stable(out_which)
                       && $stable(out_last_result))
    else $error("waiting result transaction changed");

  a_which: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_which <= sps_pkg::FN_STDDEV)
    else $error("result code out of range");

  a_mask_read: assert property (@(posedge clk) disable iff (!rst_n)
    psel && !pwrite && paddr[3:2] == sps_pkg::REG_MASK |-> prdata[31:5] == 27'd0)
    else $error("enable mask read has stray bits");

endmodule

bind segment_peak_statistics sps_check u_sps_check (.*);

// File: tb/segment_peak_statistics_checker.sv
`timescale 1ns / 100ps

module segment_peak_statistics_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  logic signed [15:0] in_sample,
  input  logic               in_last_sample,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [31:0] out_value,
  input  logic [2:0]         out_which,
  input  logic               out_last_result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fails,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] value;
    logic [2:0]         which;
    logic               last;
  } stat_result_t;

  localparam logic [2:0] FN_CODES [sps_pkg::NUM_FN] =
    '{sps_pkg::FN_COUNT, sps_pkg::FN_MEAN_DIST, sps_pkg::FN_PEAK_MEAN,
      sps_pkg::FN_PEAK_MINUS, sps_pkg::FN_STDDEV};

  stat_result_t      stat_q[$];
  logic signed [15:0] seg_mem [sps_pkg::MAX_SAMPLES];
  int                 seg_len;
  longint             seg_min, seg_max, seg_sum, prev_s, prev2_s;
  logic [4:0]         mask_r;
  logic               overlap_r;
  logic [1:0]         tnorm_r;
  logic [31:0]        period_r;

  assign pending = stat_q.size();

  initial fails = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    fails++;
  endtask

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_q16(input longint num, input longint unsigned den);
    longint unsigned mag, q, r, res;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = mag / den;
    r = mag % den;
    res = q * 65536 + (r * 65536 + den / 2) / den;
    return (num < 0) ? -longint'(res) : longint'(res);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  task automatic predict_sample(input logic signed [15:0] s, input logic closes);
    longint x, a, b, v, rng, lmin, lmax, psum, cur, lastp, pm, mean;
    longint unsigned n, start, nd, d1, d2, npk, d, dsum, dcnt, num, den, sd;
    longint unsigned var_s, nn, q, r;
    longint vals [sps_pkg::NUM_FN];
    bit flag;
    stat_result_t res;
    int cnt;
    x = s;
    if (seg_len < sps_pkg::MAX_SAMPLES) begin
      if (seg_len == 0) begin
        seg_min = x;
        seg_max = x;
        seg_sum = 0;
      end
      if (x < seg_min) seg_min = x;
      if (x > seg_max) seg_max = x;
      seg_sum += x;
      seg_mem[seg_len] = s;
      seg_len++;
    end
    if (!closes) return;
    n = seg_len;
    seg_len = 0;
    if (n == 0) return;
    rng = seg_max - seg_min;
    a = prev2_s;
    b = prev_s;
    start = 0;
    if (overlap_r) begin
      a = seg_mem[0];
      b = (n > 1) ? seg_mem[1] : seg_mem[0];
      start = 2;
    end
    lmin = 0; lmax = 0; psum = 0; cur = 0; lastp = -1; flag = 0;
    nd = 0; d1 = 0; d2 = 0; npk = 0;
    for (longint unsigned i = start; i < n; i++) begin
      v = seg_mem[i];
      if (a < b && b > v) begin
        if (!flag) lmax = v;
        else if (v > lmax) begin
          lmax = v;
          cur = i;
        end
        if (100 * (lmax - lmin) > 11 * rng) begin
          flag = 1;
          cur = i;
        end
      end else if (a > b && b < v) begin
        lmin = v;
      end
      if (flag && (100 * v < 100 * lmax - 9 * rng || i == n - 1)) begin
        npk++;
        psum += lmax;
        if (lastp >= 0) begin
          d = cur - lastp;
          nd++;
          d1 += d;
          d2 += d * d;
        end
        lastp = cur;
        flag = 0;
      end
      a = b;
      b = v;
    end
    prev2_s = a;
    prev_s = b;

    vals[0] = sat32(npk * 65536);
    dsum = nd ? d1 : n + 1;
    dcnt = nd ? nd : 1;
    if (tnorm_r == sps_pkg::TN_SECONDS) begin
      num = dsum * period_r;
      den = dcnt;
    end else if (tnorm_r == sps_pkg::TN_SEGMENT) begin
      num = dsum * 65536;
      den = dcnt * n;
    end else begin
      num = dsum * 65536;
      den = dcnt;
    end
    vals[1] = sat32((num + den / 2) / den);
    sd = 0;
    if (nd) begin
      var_s = nd * d2 - d1 * d1;
      nn = nd * nd;
      q = var_s / nn;
      r = var_s % nn;
      sd = int_sqrt(q * 64'd4294967296 + (r * 64'd4294967296) / nn);
      if (tnorm_r == sps_pkg::TN_SECONDS) sd = (sd * period_r + 32768) >> 16;
      else if (tnorm_r == sps_pkg::TN_SEGMENT) sd = (sd + n / 2) / n;
    end
    vals[4] = sat32(sd);
    pm = npk ? round_q16(psum, npk) : 0;
    mean = round_q16(seg_sum, n);
    vals[2] = sat32(pm);
    vals[3] = sat32(pm - mean);

    cnt = 0;
    for (int k = 0; k < sps_pkg::NUM_FN; k++) begin
      if (mask_r[k]) begin
        res.value = vals[k][31:0];
        res.which = FN_CODES[k];
        res.last = 0;
        stat_q.push_back(res);
        cnt++;
      end
    end
    if (cnt > 0) stat_q[stat_q.size() - 1].last = 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seg_len <= 0;
      seg_min <= 0; seg_max <= 0; seg_sum <= 0;
      prev_s <= 0; prev2_s <= 0;
      mask_r <= 5'd15; overlap_r <= 1'b1; tnorm_r <= sps_pkg::TN_FRAMES;
      period_r <= 32'd655;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          sps_pkg::REG_MASK:    mask_r <= pwdata[4:0];
          sps_pkg::REG_OVERLAP: overlap_r <= pwdata[0];
          sps_pkg::REG_TNORM:   tnorm_r <= pwdata[1:0];
          sps_pkg::REG_PERIOD:  period_r <= pwdata;
          default: ;
        endcase
      end
      if (push && !full) predict_sample(in_sample, in_last_sample);
      if (pop && !empty) begin
        if (stat_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d which=%0d",
                                    out_value, out_which));
        end else begin
          stat_result_t e;
          e = stat_q.pop_front();
          if (out_value !== e.value || out_which !== e.which || out_last_result !== e.last)
            report_mismatch($sformatf("got value=%0d which=%0d last=%0b, exp %0d %0d %0b",
                                      out_value, out_which, out_last_result,
                                      e.value, e.which, e.last));
        end
      end
    end
  end

endmodule

// File: tb/tb_segment_peak_statistics.sv
`timescale 1ns / 100ps

module tb_segment_peak_statistics;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] in_sample = '0;
  logic               in_last_sample = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] out_value;
  logic [2:0]         out_which;
  logic               out_last_result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 fails;
  int                 pending;
  int                 send_idle_pct = 25;
  int                 recv_idle_pct = 64;
  int                 sent = 0;

  segment_peak_statistics DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_sample(in_sample), .in_last_sample(in_last_sample),
    .empty(empty), .pop(pop), .out_value(out_value), .out_which(out_which),
    .out_last_result(out_last_result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  segment_peak_statistics_checker u_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_sample(in_sample), .in_last_sample(in_last_sample),
    .empty(empty), .pop(pop), .out_value(out_value), .out_which(out_which),
    .out_last_result(out_last_result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_sample(input logic signed [15:0] s, input logic closes);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_sample <= s;
    in_last_sample <= closes;
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    push <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2500) @(posedge clk);
  endtask

  task automatic configure(input logic [4:0] mask, input logic ovl, input logic [1:0] tn,
                           input logic [31:0] period);
    drain();
    write_reg(sps_pkg::REG_MASK, {27'd0, mask});
    write_reg(sps_pkg::REG_OVERLAP, {31'd0, ovl});
    write_reg(sps_pkg::REG_TNORM, {30'd0, tn});
    write_reg(sps_pkg::REG_PERIOD, period);
  endtask

  task automatic send_segment(input int len);
    int lvl, amp, val;
    bit noisy;
    noisy = ($urandom_range(99) < 20);
    lvl = $urandom_range(40000) - 20000;
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        val = $signed(16'($urandom));
      end else begin
        amp = $urandom_range(($urandom_range(3) == 0) ? 30000 : 3000);
        lvl += $urandom_range(2000) - 1000;
        val = (i % 2) ? lvl + amp : lvl - amp;
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
      end
      send_sample(16'(val), i == len - 1);
    end
  endtask

  task automatic send_random(input int items);
    int target;
    target = sent + items;
    while (sent < target)
      send_segment(($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b1);
    for (int i = 0; i < 8; i++)
      send_sample((i % 2) ? -16'sd32768 : 16'sd32767, i == 7);
    for (int i = 0; i < 6; i++)
      send_sample((i % 3 == 1) ? 16'sd100 : -16'sd50, i == 5);

    configure(5'd31, 1'b0, sps_pkg::TN_SECONDS, 32'hFFFF_FFFF);
    for (int i = 0; i < 40; i++)
      send_sample(16'($urandom_range(2000)) - ((i % 2) ? 16'sd0 : 16'sd1500), i == 39);
    send_random(40);

    configure(5'd0, 1'b1, 2'd3, 32'd0);
    send_random(10);

    send_idle_pct = 64;
    recv_idle_pct = 25;
    configure(5'd31, 1'b1, sps_pkg::TN_SEGMENT, 32'd1);
    send_random(40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(5'($urandom_range(1, 31)), 1'($urandom), sps_pkg::TN_SECONDS, $urandom);
    send_random(25);
    configure(5'd31, 1'b0, sps_pkg::TN_FRAMES, 32'd655);
    send_random(25);

    drain();
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
